// File: sv/sais_pkg.sv
// Shared types and constants for the sorted key store.
// No dependencies; imported by sorted_array_insert_search.
package sais_pkg;

  localparam int unsigned DEPTH     = 256;
  localparam int unsigned KEY_WIDTH = 32;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);

  // Request codes
  typedef enum logic [1:0] {
    MODE_FIND     = 2'd0,
    MODE_SORT_INS = 2'd1,
    MODE_INS_AT   = 2'd2,
    MODE_REPLACE  = 2'd3
  } mode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SRCH    = 8'b0000_0010,
    S_CMP     = 8'b0000_0100,
    S_CHK_LO  = 8'b0000_1000,
    S_CHK_HI  = 8'b0001_0000,
    S_CHK_END = 8'b0010_0000,
    S_SHIFT   = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_e;

endpackage

// File: sv/sais_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sais_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/sorted_array_insert_search.sv
// Sorted key store: binary search, sorted insert, guarded insert-at and replace-at.
// Uses sais_pkg and one sais_ram instance holding the keys.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request word: mode_i,
//   key_i and position_i. Output channel (out_valid_o / out_stall_i) returns one
//   result word per request: status_o, result_position_o and count_o.
//   One request is processed at a time; in_stall_o is high while it is at work.
//   Steps from accept to result valid, with n keys stored:
//     find / search part of sorted insert: S_SRCH probes, S_CMP compares; a hit ends in S_CMP
//     insert shift: S_SHIFT moves entries p to n - 1 up one, then writes the key at p
//     insert-at / replace-at: S_CHK_LO, S_CHK_HI, S_CHK_END, plus the shift for insert-at
//     bad position or full store: straight to S_DONE
//   The single key RAM port pair bounds the speed: one probe at a time while searching,
//   one entry moved per cycle while shifting; probes <= log2(n) + 1.
//   The result sits in an output register; the next request is accepted while it
//   waits. A stalled result holds until taken and then blocks only the next
//   completion. Reset empties the store (count 0); key RAM contents are not
//   cleared, as only entries below the count are ever used.
module sorted_array_insert_search
  import sais_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] key_i,
  input  logic [8:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [8:0]  result_position_o,
  output logic [8:0]  count_o
);

  // Control registers
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pend_q, pend_d;
  logic             rej_q, rej_d;
  logic             out_valid_q, out_valid_d;

  // Working registers
  mode_e              mode_q, mode_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   lo_q, lo_d;
  logic [CNT_W-1:0]   hi_q, hi_d;
  logic [ADDR_W-1:0]  mid_q, mid_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [ADDR_W-1:0]  pend_addr_q, pend_addr_d;
  logic               has_lo_q, has_lo_d;
  logic               has_hi_q, has_hi_d;
  status_e            status_q, status_d;
  logic [CNT_W-1:0]   rpos_q, rpos_d;

  // Output word
  logic [1:0]       out_status_q;
  logic [CNT_W-1:0] out_rpos_q;
  logic [CNT_W-1:0] out_count_q;
  logic             out_load;

  // RAM port signals
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;

  logic [CNT_W:0]       mid_sum;
  logic [ADDR_W-1:0]    mid_w;
  logic [CNT_W-1:0]     depth_cnt;
  logic [CNT_W:0]       pos_next;

  sais_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(DEPTH)
  ) u_keys (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Probe index: midpoint of the inclusive bounds lo and hi-1, rounded down
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q} - (CNT_W + 1)'(1);
  assign mid_w     = mid_sum[ADDR_W:1];
  assign depth_cnt = CNT_W'(DEPTH);
  assign pos_next  = {1'b0, position_i} + (CNT_W + 1)'(1);

  assign in_stall_o = (state_q != S_IDLE);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pend_d      = pend_q;
    rej_d       = rej_q;
    mode_d      = mode_q;
    key_d       = key_q;
    pos_d       = pos_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    idx_d       = idx_q;
    pend_addr_d = pend_addr_q;
    has_lo_d    = has_lo_q;
    has_hi_d    = has_hi_q;
    status_d    = status_q;
    rpos_d      = rpos_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q & out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = pend_addr_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = mid_w;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d   = mode_e'(mode_i);
          key_d    = key_i[KEY_WIDTH-1:0];
          pos_d    = position_i;
          lo_d     = '0;
          hi_d     = count_q;
          rpos_d   = '0;
          status_d = ST_DONE;
          rej_d    = 1'b0;
          has_lo_d = (position_i != '0);
          if (mode_i == MODE_INS_AT) begin
            has_hi_d = (position_i < count_q);
          end else begin
            has_hi_d = (pos_next < {1'b0, count_q});
          end
          case (mode_e'(mode_i))
            MODE_FIND: begin
              state_d = S_SRCH;
            end
            MODE_SORT_INS: begin
              if (count_q >= depth_cnt) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                state_d = S_SRCH;
              end
            end
            MODE_INS_AT: begin
              if (position_i > count_q) begin
                status_d = ST_BADPOS;
                state_d  = S_DONE;
              end else if (count_q >= depth_cnt) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                state_d = S_CHK_LO;
              end
            end
            MODE_REPLACE: begin
              if (position_i >= count_q) begin
                status_d = ST_BADPOS;
                state_d  = S_DONE;
              end else begin
                state_d = S_CHK_LO;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // Issue a probe, or settle on the insertion point
      S_SRCH: begin
        if (lo_q < hi_q) begin
          ram_raddr = mid_w;
          mid_d     = mid_w;
          state_d   = S_CMP;
        end else begin
          rpos_d = lo_q;
          if (mode_q == MODE_FIND) begin
            state_d = S_DONE;
          end else begin
            pos_d   = lo_q;
            idx_d   = count_q;
            state_d = S_SHIFT;
          end
        end
      end

      // Compare the probed key and narrow the bounds
      S_CMP: begin
        if (key_q == ram_rdata) begin
          rpos_d = {1'b0, mid_q};
          if (mode_q == MODE_FIND) begin
            state_d = S_DONE;
          end else begin
            pos_d   = {1'b0, mid_q};
            idx_d   = count_q;
            state_d = S_SHIFT;
          end
        end else if (key_q < ram_rdata) begin
          hi_d    = {1'b0, mid_q};
          state_d = S_SRCH;
        end else begin
          lo_d    = {1'b0, mid_q} + CNT_W'(1);
          state_d = S_SRCH;
        end
      end

      // Read the neighbor below the position
      S_CHK_LO: begin
        ram_raddr = ADDR_W'(pos_q - CNT_W'(1));
        state_d   = S_CHK_HI;
      end

      // Check the lower neighbor, read the upper one
      S_CHK_HI: begin
        if (has_lo_q && (ram_rdata > key_q)) begin
          rej_d = 1'b1;
        end
        if (mode_q == MODE_INS_AT) begin
          ram_raddr = pos_q[ADDR_W-1:0];
        end else begin
          ram_raddr = pos_q[ADDR_W-1:0] + ADDR_W'(1);
        end
        state_d = S_CHK_END;
      end

      // Check the upper neighbor and commit
      S_CHK_END: begin
        if (rej_q || (has_hi_q && (key_q > ram_rdata))) begin
          status_d = ST_REJECT;
          state_d  = S_DONE;
        end else if (mode_q == MODE_REPLACE) begin
          ram_we    = 1'b1;
          ram_waddr = pos_q[ADDR_W-1:0];
          ram_wdata = key_q;
          state_d   = S_DONE;
        end else begin
          idx_d   = count_q;
          state_d = S_SHIFT;
        end
      end

      // Move entries up one per cycle, then drop the key into the gap
      S_SHIFT: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_q;
          ram_wdata = ram_rdata;
        end
        if (idx_q > pos_q) begin
          ram_raddr   = ADDR_W'(idx_q - CNT_W'(1));
          pend_d      = 1'b1;
          pend_addr_d = idx_q[ADDR_W-1:0];
          idx_d       = idx_q - CNT_W'(1);
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_q[ADDR_W-1:0];
          ram_wdata = key_q;
          count_d   = count_q + CNT_W'(1);
          state_d   = S_DONE;
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      rej_q       <= rej_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    key_q       <= key_d;
    pos_q       <= pos_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    idx_q       <= idx_d;
    pend_addr_q <= pend_addr_d;
    has_lo_q    <= has_lo_d;
    has_hi_q    <= has_hi_d;
    status_q    <= status_d;
    rpos_q      <= rpos_d;
  end

  // Output word
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_q;
      out_rpos_q   <= rpos_q;
      out_count_q  <= count_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign result_position_o = out_rpos_q;
  assign count_o           = out_count_q;

  // The count never exceeds the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= depth_cnt)
    else $error("count exceeds depth");

  // The count only grows, by one, at the end of a shift
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_d != count_q) |-> (state_q == S_SHIFT && count_d == count_q + CNT_W'(1)))
    else $error("count changed outside an insert");

  // The key RAM is written only while committing or shifting
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_SHIFT || state_q == S_CHK_END))
    else $error("key RAM written in wrong state");

  // A pending shift write stays inside the filled region plus the new slot
  a_pend_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ({1'b0, pend_addr_q} <= count_q))
    else $error("shift write beyond count");

  // A result is loaded only when the output register is free or being drained
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

endmodule

// File: tb/sorted_array_insert_search_tb.sv
`timescale 1ns / 1ps
// Testbench for sorted_array_insert_search: a directed table of requests, then random
// requests, each scored against its table result or an in-bench model of the sorted key store.
// Depends on sais_pkg and the sorted_array_insert_search RTL.
module sorted_array_insert_search_tb
  import sais_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned RANDOM_WORDS = 1600;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic [31:0] KEY_MAX      = 32'hFFFF_FFFF;

  typedef struct {
    status_e     status;
    logic [8:0]  slot;
    logic [8:0]  count;
  } result_t;

  typedef struct {
    mode_e       mode;
    logic [31:0] key;
    logic [8:0]  pos;
    bit          typed;
    result_t     res;
  } request_t;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i            = MODE_FIND;
  logic [31:0] key_i             = '0;
  logic [8:0]  position_i        = '0;
  logic        out_valid_o;
  logic        out_stall_i       = 1'b0;
  logic [1:0]  status_o;
  logic [8:0]  result_position_o;
  logic [8:0]  count_o;

  // Model of the store and the results still owed by the block
  logic [31:0] store_keys [DEPTH];
  int unsigned key_count    = 0;
  result_t     pending_results [$];
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  bit          quiet        = 1'b0;

  sorted_array_insert_search i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .key_i             (key_i),
    .position_i        (position_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .result_position_o (result_position_o),
    .count_o           (count_o)
  );

  always #2 clk_i = ~clk_i;

  // Binary search over the stored keys: first probe that hits, else the insertion point
  function automatic int probe_slot(logic [31:0] k);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = int'(key_count) - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (k == store_keys[mid]) return mid;
      if (k < store_keys[mid]) hi = mid - 1;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  // Shift the upper entries up by one and drop the key into the gap
  function automatic void place_key(int slot, logic [31:0] k);
    for (int i = int'(key_count); i > slot; i--) store_keys[i] = store_keys[i-1];
    store_keys[slot] = k;
    key_count++;
  endfunction

  // Apply one request word to the model and return the result word it owes
  function automatic result_t apply_request(mode_e md, logic [31:0] k, logic [8:0] p);
    result_t r;
    int      ip;
    int      cnt;
    int      slot;
    ip       = int'(p);
    cnt      = int'(key_count);
    r.status = ST_DONE;
    r.slot   = '0;
    case (md)
      MODE_FIND: begin
        r.slot = 9'(probe_slot(k));
      end
      MODE_SORT_INS: begin
        if (cnt >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot   = probe_slot(k);
          r.slot = 9'(slot);
          place_key(slot, k);
        end
      end
      MODE_INS_AT: begin
        if (ip > cnt) r.status = ST_BADPOS;
        else if (cnt >= DEPTH) r.status = ST_FULL;
        else if ((ip > 0 && store_keys[ip-1] > k) || (ip < cnt && k > store_keys[ip]))
          r.status = ST_REJECT;
        else place_key(ip, k);
      end
      default: begin
        if (ip >= cnt) r.status = ST_BADPOS;
        else if ((ip > 0 && store_keys[ip-1] > k) ||
                 (ip + 1 < cnt && k > store_keys[ip+1]))
          r.status = ST_REJECT;
        else store_keys[ip] = k;
      end
    endcase
    r.count = 9'(key_count);
    return r;
  endfunction

  // Key that keeps order between two neighbors, ties included
  function automatic logic [31:0] key_between(logic [31:0] lo, logic [31:0] hi);
    case ($urandom_range(3))
      0:       return lo;
      1:       return hi;
      default: return (lo == '0 && hi == KEY_MAX) ? $urandom() : $urandom_range(hi, lo);
    endcase
  endfunction

  // Free key: random (three in eight), some crowded small values, some copies, a few extremes
  function automatic logic [31:0] pick_key();
    case ($urandom_range(7))
      3, 4:    return 32'($urandom_range(15));
      5, 6:    return key_count > 0 ? store_keys[$urandom_range(key_count - 1)] : 32'h0;
      7:       return $urandom_range(1) ? KEY_MAX : 32'h0;
      default: return $urandom();
    endcase
  endfunction

  // Offer one request word, hold it until taken, then predict its result
  task automatic send_word(request_t rq);
    result_t got;
    while (!quiet && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= rq.mode;
    key_i      <= rq.key;
    position_i <= rq.pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    got = apply_request(rq.mode, rq.key, rq.pos);
    pending_results.push_back(rq.typed ? rq.res : got);
  endtask

  // Directed requests; rows marked typed carry their result, the rest use the model
  request_t dir_rows [25] = '{
    '{MODE_FIND,     32'h0,         9'd0,   1'b1, '{ST_DONE,   9'd0, 9'd0}},
    '{MODE_FIND,     32'hFFFF_FFFF, 9'h1FF, 1'b1, '{ST_DONE,   9'd0, 9'd0}},
    '{MODE_REPLACE,  32'd5,         9'd0,   1'b1, '{ST_BADPOS, 9'd0, 9'd0}},
    '{MODE_INS_AT,   32'd100,       9'd1,   1'b1, '{ST_BADPOS, 9'd0, 9'd0}},
    '{MODE_INS_AT,   32'd100,       9'd0,   1'b1, '{ST_DONE,   9'd0, 9'd1}},
    '{MODE_REPLACE,  32'd5,         9'd0,   1'b1, '{ST_DONE,   9'd0, 9'd1}},
    '{MODE_SORT_INS, 32'hFFFF_FFFF, 9'd0,   1'b1, '{ST_DONE,   9'd1, 9'd2}},
    '{MODE_SORT_INS, 32'h0,         9'd0,   1'b1, '{ST_DONE,   9'd0, 9'd3}},
    '{MODE_INS_AT,   32'h10,        9'd3,   1'b1, '{ST_REJECT, 9'd0, 9'd3}},
    '{MODE_INS_AT,   32'hFFFF_FFFF, 9'd3,   1'b1, '{ST_DONE,   9'd0, 9'd4}},
    '{MODE_INS_AT,   32'd1,         9'd0,   1'b1, '{ST_REJECT, 9'd0, 9'd4}},
    '{MODE_INS_AT,   32'd5,         9'd1,   1'b1, '{ST_DONE,   9'd0, 9'd5}},
    '{MODE_SORT_INS, 32'd5,         9'd0,   1'b1, '{ST_DONE,   9'd2, 9'd6}},
    '{MODE_FIND,     32'd5,         9'd0,   1'b1, '{ST_DONE,   9'd2, 9'd6}},
    '{MODE_FIND,     32'd3,         9'd0,   1'b1, '{ST_DONE,   9'd1, 9'd6}},
    '{MODE_REPLACE,  32'd6,         9'd0,   1'b1, '{ST_REJECT, 9'd0, 9'd6}},
    '{MODE_REPLACE,  32'd0,         9'd5,   1'b1, '{ST_REJECT, 9'd0, 9'd6}},
    '{MODE_REPLACE,  32'hFFFF_FFFF, 9'd5,   1'b1, '{ST_DONE,   9'd0, 9'd6}},
    '{MODE_REPLACE,  32'd9,         9'd6,   1'b1, '{ST_BADPOS, 9'd0, 9'd6}},
    '{MODE_REPLACE,  32'd9,         9'h1FF, 1'b1, '{ST_BADPOS, 9'd0, 9'd6}},
    '{MODE_INS_AT,   32'd9,         9'd7,   1'b1, '{ST_BADPOS, 9'd0, 9'd6}},
    '{MODE_INS_AT,   32'd9,         9'd256, 1'b1, '{ST_BADPOS, 9'd0, 9'd6}},
    '{MODE_FIND,     32'hFFFF_FFFF, 9'd0,   1'b1, '{ST_DONE,   9'd4, 9'd6}},
    '{MODE_SORT_INS, 32'h8000_0000, 9'd0,   1'b0, '{ST_DONE,   9'd0, 9'd0}},
    '{MODE_INS_AT,   32'h0,         9'd0,   1'b0, '{ST_DONE,   9'd0, 9'd0}}
  };

  // Reset, directed table, random requests, drain
  initial begin : stimulus
    request_t    rq;
    int          roll;
    int          sel;
    int          slot;
    logic [31:0] lo;
    logic [31:0] hi;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) send_word(dir_rows[i]);

    rq.typed = 1'b0;
    rq.res   = '{ST_DONE, 9'd0, 9'd0};
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // Hold a stretch with no idling on either side
      quiet  = (n >= 300 && n < 500);
      roll   = $urandom_range(99);
      sel    = $urandom_range(9);
      rq.key = pick_key();
      rq.pos = 9'($urandom());
      if (roll < 30) begin
        rq.mode = MODE_FIND;
      end else if (roll < 50) begin
        rq.mode = MODE_SORT_INS;
      end else if (roll < 70) begin
        rq.mode = MODE_INS_AT;
        if (sel < 8) begin
          slot   = $urandom_range(key_count);
          lo     = slot > 0 ? store_keys[slot-1] : '0;
          hi     = slot < int'(key_count) ? store_keys[slot] : KEY_MAX;
          rq.pos = 9'(slot);
          if (sel < 7) rq.key = key_between(lo, hi);
        end else begin
          rq.pos = 9'($urandom_range(511, key_count + 1));
        end
      end else begin
        rq.mode = MODE_REPLACE;
        if (sel < 8 && key_count > 0) begin
          slot   = $urandom_range(key_count - 1);
          lo     = slot > 0 ? store_keys[slot-1] : '0;
          hi     = slot + 1 < int'(key_count) ? store_keys[slot+1] : KEY_MAX;
          rq.pos = 9'(slot);
          if (sel < 7) rq.key = key_between(lo, hi);
        end else begin
          rq.pos = 9'($urandom_range(511, key_count));
        end
      end
      send_word(rq);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Score each result word taken from the block against the oldest prediction
  always @(posedge clk_i) begin : score_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result word: status %0d pos %0d count %0d",
                   status_o, result_position_o, count_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o != want.status || result_position_o != want.slot ||
            count_o != want.count) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result mismatch: expected status %0d pos %0d count %0d, got %0d %0d %0d",
                     want.status, want.slot, want.count,
                     status_o, result_position_o, count_o);
        end
      end
    end
    out_stall_i <= !quiet && ($urandom_range(99) < 33);
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// File: files.f
sv/sais_pkg.sv
sv/sais_ram.sv
sv/sorted_array_insert_search.sv
tb/sorted_array_insert_search_tb.sv
